@@ rtl/gcrs_pkg.sv @@
// shared types and constants of the gray class run segmenter
`default_nettype none

package gcrs_pkg;

    localparam int PIX_W      = 16;
    localparam int POS_W      = 12;
    localparam int LEN_W      = 13;
    localparam int CLS_W      = 3;
    localparam int CFG_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int NUM_RANGES = 5;
    localparam int LEN_MAX    = 4096;

    // register indexes, which are also the classification priority order
    localparam logic [CFG_IDX_W-1:0] REG_WHITE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PLATE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPRING = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BLACK  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BAR    = 3'd4;

    typedef enum logic [CLS_W-1:0] {
        CLS_WHITE  = 3'd0,
        CLS_SPRING = 3'd1,
        CLS_PLATE  = 3'd2,
        CLS_BLACK  = 3'd3,
        CLS_OTHER  = 3'd4,
        CLS_BAR    = 3'd5
    } gray_class_t;

    typedef logic [NUM_RANGES-1:0][CFG_W-1:0] range_set_t;

    typedef struct packed {
        logic              line_done;
        logic [POS_W-1:0]  seg_end;
        logic [POS_W-1:0]  seg_start;
        logic [LEN_W-1:0]  seg_length;
        gray_class_t       seg_class;
    } seg_word_t;

    // up to two result words pushed in one cycle
    typedef struct packed {
        logic [1:0] cnt;
        seg_word_t  first;
        seg_word_t  second;
    } seg_push_t;

    typedef struct packed {
        logic room_for_two;
        logic out_valid;
    } fifo_status_t;

endpackage

`default_nettype wire

@@ rtl/gcrs_classify.sv @@
// gray class lookup of one pixel against the five programmed ranges
`default_nettype none

module gcrs_classify (
    input  wire logic [gcrs_pkg::PIX_W-1:0] pixel,
    input  wire gcrs_pkg::range_set_t       ranges,
    output gcrs_pkg::gray_class_t           pix_class
);

    logic [gcrs_pkg::NUM_RANGES-1:0] hit;

    // inclusive bounds, low in the lower half; low above high never hits
    always_comb begin
        for (int i = 0; i < gcrs_pkg::NUM_RANGES; i++) begin
            hit[i] = (pixel >= ranges[i][15:0]) && (pixel <= ranges[i][31:16]);
        end
    end

    always_comb begin
        priority if (hit[gcrs_pkg::REG_WHITE]) begin
            pix_class = gcrs_pkg::CLS_WHITE;
        end else if (hit[gcrs_pkg::REG_PLATE]) begin
            pix_class = gcrs_pkg::CLS_PLATE;
        end else if (hit[gcrs_pkg::REG_SPRING]) begin
            pix_class = gcrs_pkg::CLS_SPRING;
        end else if (hit[gcrs_pkg::REG_BLACK]) begin
            pix_class = gcrs_pkg::CLS_BLACK;
        end else if (hit[gcrs_pkg::REG_BAR]) begin
            pix_class = gcrs_pkg::CLS_BAR;
        end else begin
            pix_class = gcrs_pkg::CLS_OTHER;
        end
    end

endmodule

`default_nettype wire

@@ rtl/gcrs_res_fifo.sv @@
// four-entry result queue, two words in and one word out per cycle
`default_nettype none

module gcrs_res_fifo (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire gcrs_pkg::seg_push_t push,
    input  wire logic              pop,
    output gcrs_pkg::seg_word_t    head,
    output gcrs_pkg::fifo_status_t status
);

    gcrs_pkg::seg_word_t entry_reg [4];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] count_reg, count_next;
    logic       do_pop;

    assign do_pop      = pop && (count_reg != 3'd0);
    assign wr_ptr_next = wr_ptr_reg + push.cnt;
    assign rd_ptr_next = rd_ptr_reg + {1'b0, do_pop};
    assign count_next  = count_reg + {1'b0, push.cnt} - {2'b00, do_pop};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.cnt != 2'd0) begin
            entry_reg[wr_ptr_reg] <= push.first;
        end
        if (push.cnt == 2'd2) begin
            entry_reg[wr_ptr_reg + 2'd1] <= push.second;
        end
    end

    assign head                = entry_reg[rd_ptr_reg];
    assign status.out_valid    = (count_reg != 3'd0);
    assign status.room_for_two = (count_reg <= 3'd2);

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 3'd4)
        else $error("result queue over four words");

    a_push_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, push.cnt} + count_reg) <= 3'd4)
        else $error("push with no room in result queue");

    a_count_track: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |->
        count_reg == $past(count_reg) + {1'b0, $past(push.cnt)}
                     - {2'b00, $past(do_pop)})
        else $error("result queue count out of step with pointers");

    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_ptr_reg - rd_ptr_reg) == count_reg[1:0])
        else $error("result queue pointers disagree with count");

endmodule

`default_nettype wire

@@ rtl/gray_class_run_segmenter_core.sv @@
// gray class run segmenter: splits an image line into runs of equal gray class
// Each pixel word is sorted into a gray class by five programmable inclusive
// ranges (white, plate, spring, black, bar, else other) and the current run is
// extended or closed. A closed run and the final run of a line (s_tlast) leave
// as words on the master side, m_tlast marking the final run. The block takes
// one pixel per clock: a pixel goes from the input register through the
// classifier and run update into a four-entry result queue, and the words it
// causes are registered in the queue and offered on the master side from
// there. The queue drains one word per clock while m_tready is high, so a pixel
// that both closes a run and ends the line leaves two words one after the other;
// the input stalls only while the queue holds three or more words. Run length
// saturates at the smaller of LINE_LENGTH and 4096.
`default_nettype none

module gray_class_run_segmenter_core #(
    parameter int LINE_LENGTH = 4096
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // pixel stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // pixel[15:0], position[27:16], zero fill
    input  wire logic        s_tlast,   // last_pixel
    // run stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // seg_class[2:0], seg_length[15:3],
                                        // seg_start[27:16], seg_end[39:28]
    output logic             m_tlast,   // line_done
    // configuration
    input  wire logic                            cfg_we,
    input  wire logic [gcrs_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  wire logic [gcrs_pkg::CFG_W-1:0]      cfg_wdata
);

    localparam int LenCap = (LINE_LENGTH < gcrs_pkg::LEN_MAX) ? LINE_LENGTH
                                                              : gcrs_pkg::LEN_MAX;
    localparam logic [gcrs_pkg::LEN_W-1:0] LEN_CAP = LenCap[gcrs_pkg::LEN_W-1:0];

    gcrs_pkg::range_set_t ranges_reg;

    logic                        in_valid_reg;
    logic [gcrs_pkg::PIX_W-1:0]  in_pixel_reg;
    logic [gcrs_pkg::POS_W-1:0]  in_pos_reg;
    logic                        in_last_reg;

    gcrs_pkg::gray_class_t       run_class_reg, run_class_next;
    logic [gcrs_pkg::LEN_W-1:0]  run_length_reg, run_length_next;
    logic [gcrs_pkg::POS_W-1:0]  run_start_reg, run_start_next;

    gcrs_pkg::gray_class_t       pix_class;
    gcrs_pkg::seg_push_t         push;
    gcrs_pkg::seg_word_t         closed_word, final_word, head;
    gcrs_pkg::fifo_status_t      status;

    logic proc, run_open, change;
    gcrs_pkg::gray_class_t       upd_class;
    logic [gcrs_pkg::LEN_W-1:0]  upd_length;
    logic [gcrs_pkg::POS_W-1:0]  upd_start;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ranges_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                gcrs_pkg::REG_WHITE:  ranges_reg[gcrs_pkg::REG_WHITE]  <= cfg_wdata;
                gcrs_pkg::REG_PLATE:  ranges_reg[gcrs_pkg::REG_PLATE]  <= cfg_wdata;
                gcrs_pkg::REG_SPRING: ranges_reg[gcrs_pkg::REG_SPRING] <= cfg_wdata;
                gcrs_pkg::REG_BLACK:  ranges_reg[gcrs_pkg::REG_BLACK]  <= cfg_wdata;
                gcrs_pkg::REG_BAR:    ranges_reg[gcrs_pkg::REG_BAR]    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // input register
    assign proc     = in_valid_reg && status.room_for_two;
    assign s_tready = !in_valid_reg || proc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_pixel_reg <= s_tdata[15:0];
            in_pos_reg   <= s_tdata[27:16];
            in_last_reg  <= s_tlast;
        end
    end

    gcrs_classify u_classify (
        .pixel     (in_pixel_reg),
        .ranges    (ranges_reg),
        .pix_class (pix_class)
    );

    // run update
    assign run_open = (run_length_reg != '0);
    assign change   = run_open && (pix_class != run_class_reg);

    always_comb begin
        if (!run_open || change) begin
            upd_class  = pix_class;
            upd_length = gcrs_pkg::LEN_W'(1);
            upd_start  = in_pos_reg;
        end else begin
            upd_class  = run_class_reg;
            upd_length = (run_length_reg < LEN_CAP) ? run_length_reg + 1'b1
                                                    : run_length_reg;
            upd_start  = run_start_reg;
        end
    end

    always_comb begin
        closed_word.seg_class  = run_class_reg;
        closed_word.seg_length = run_length_reg;
        closed_word.seg_start  = run_start_reg;
        closed_word.seg_end    = in_pos_reg - 1'b1;
        closed_word.line_done  = 1'b0;

        final_word.seg_class   = upd_class;
        final_word.seg_length  = upd_length;
        final_word.seg_start   = upd_start;
        final_word.seg_end     = in_pos_reg;
        final_word.line_done   = 1'b1;
    end

    always_comb begin
        push.first  = change ? closed_word : final_word;
        push.second = final_word;
        if (!proc) begin
            push.cnt = 2'd0;
        end else begin
            push.cnt = {1'b0, change} + {1'b0, in_last_reg};
        end
    end

    always_comb begin
        run_class_next  = run_class_reg;
        run_length_next = run_length_reg;
        run_start_next  = run_start_reg;
        if (proc) begin
            if (in_last_reg) begin
                run_class_next  = gcrs_pkg::CLS_WHITE;
                run_length_next = '0;
                run_start_next  = '0;
            end else begin
                run_class_next  = upd_class;
                run_length_next = upd_length;
                run_start_next  = upd_start;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_class_reg  <= gcrs_pkg::CLS_WHITE;
            run_length_reg <= '0;
            run_start_reg  <= '0;
        end else begin
            run_class_reg  <= run_class_next;
            run_length_reg <= run_length_next;
            run_start_reg  <= run_start_next;
        end
    end

    gcrs_res_fifo u_res_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .pop     (m_tready),
        .head    (head),
        .status  (status)
    );

    assign m_tvalid = status.out_valid;
    assign m_tdata  = {head.seg_end, head.seg_start, head.seg_length, head.seg_class};
    assign m_tlast  = head.line_done;

    a_open_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc && !in_last_reg) |=> (run_length_reg != '0))
        else $error("run closed without a last pixel");

    a_len_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        run_length_reg <= LEN_CAP)
        else $error("run length above cap");

    a_last_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc && in_last_reg) |=> (run_length_reg == '0))
        else $error("run left open after last pixel");

endmodule

`default_nettype wire

@@ bench/tb.sv @@
// testbench for gray_class_run_segmenter_core with a run predictor and word scoreboard
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_LENGTH  = 4096;
    localparam int LEN_CAP      = (LINE_LENGTH < gcrs_pkg::LEN_MAX) ? LINE_LENGTH
                                                                    : gcrs_pkg::LEN_MAX;
    localparam int DRAIN_CYCLES = 8;
    localparam int LONG_RUN     = LEN_CAP + 4;
    localparam int RANDOM_PIXELS = 1900;

    localparam logic [gcrs_pkg::CFG_IDX_W-1:0] REG_IDX [gcrs_pkg::NUM_RANGES] =
        '{gcrs_pkg::REG_WHITE, gcrs_pkg::REG_PLATE, gcrs_pkg::REG_SPRING,
          gcrs_pkg::REG_BLACK, gcrs_pkg::REG_BAR};

    logic                           aclk = 1'b0;
    logic                           aresetn;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [31:0]                    s_tdata;   // pixel[15:0], position[27:16], zero fill
    logic                           s_tlast;   // last_pixel
    logic                           m_tvalid;
    logic                           m_tready;
    logic [39:0]                    m_tdata;   // seg_class[2:0], seg_length[15:3],
                                               // seg_start[27:16], seg_end[39:28]
    logic                           m_tlast;   // line_done
    logic                           cfg_we;
    logic [gcrs_pkg::CFG_IDX_W-1:0] cfg_addr;
    logic [gcrs_pkg::CFG_W-1:0]     cfg_wdata;

    gray_class_run_segmenter_core #(.LINE_LENGTH(LINE_LENGTH)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    class run_scoreboard;
        logic [gcrs_pkg::CFG_W-1:0] ranges [gcrs_pkg::NUM_RANGES];
        gcrs_pkg::gray_class_t      open_cls;
        int unsigned                open_len;
        logic [gcrs_pkg::POS_W-1:0] open_start;
        gcrs_pkg::seg_word_t        seg_q [$];
        int                         errors;

        function new();
            foreach (ranges[i]) ranges[i] = '0;
            open_cls   = gcrs_pkg::CLS_WHITE;
            open_len   = 0;
            open_start = '0;
            errors     = 0;
        endfunction

        function void set_range(logic [gcrs_pkg::CFG_IDX_W-1:0] idx,
                                logic [gcrs_pkg::CFG_W-1:0] val);
            if (idx <= gcrs_pkg::REG_BAR) ranges[idx] = val;
        endfunction

        // fixed priority follows the register order, first hit wins
        function gcrs_pkg::gray_class_t sort_pixel(logic [gcrs_pkg::PIX_W-1:0] pix);
            gcrs_pkg::gray_class_t band_cls [gcrs_pkg::NUM_RANGES] =
                '{gcrs_pkg::CLS_WHITE, gcrs_pkg::CLS_PLATE, gcrs_pkg::CLS_SPRING,
                  gcrs_pkg::CLS_BLACK, gcrs_pkg::CLS_BAR};
            for (int i = 0; i < gcrs_pkg::NUM_RANGES; i++) begin
                if (pix >= ranges[REG_IDX[i]][15:0] && pix <= ranges[REG_IDX[i]][31:16])
                    return band_cls[i];
            end
            return gcrs_pkg::CLS_OTHER;
        endfunction

        function void close_run(logic [gcrs_pkg::POS_W-1:0] end_pos, logic done);
            gcrs_pkg::seg_word_t w;
            w.seg_class  = open_cls;
            w.seg_length = gcrs_pkg::LEN_W'(open_len);
            w.seg_start  = open_start;
            w.seg_end    = end_pos;
            w.line_done  = done;
            seg_q = {seg_q, w};
        endfunction

        function void note_pixel(logic [gcrs_pkg::PIX_W-1:0] pix,
                                 logic [gcrs_pkg::POS_W-1:0] pos, logic last);
            gcrs_pkg::gray_class_t cls;
            cls = sort_pixel(pix);
            if (open_len == 0) begin
                open_cls   = cls;
                open_len   = 1;
                open_start = pos;
            end else if (cls == open_cls) begin
                if (open_len < LEN_CAP) open_len++;
            end else begin
                close_run(pos - 1'b1, 1'b0);
                open_cls   = cls;
                open_len   = 1;
                open_start = pos;
            end
            if (last) begin
                close_run(pos, 1'b1);
                open_cls   = gcrs_pkg::CLS_WHITE;
                open_len   = 0;
                open_start = '0;
            end
        endfunction

        function void check_word(logic [39:0] data, logic last);
            gcrs_pkg::seg_word_t w;
            if (seg_q.size() == 0) begin
                $error("unexpected word: data %h last %b", data, last);
                errors++;
                return;
            end
            w = seg_q.pop_front();
            if (data[2:0] !== w.seg_class) begin
                $error("seg_class: expected %0d, actual %0d", w.seg_class, data[2:0]);
                errors++;
            end
            if (data[15:3] !== w.seg_length) begin
                $error("seg_length: expected %0d, actual %0d", w.seg_length, data[15:3]);
                errors++;
            end
            if (data[27:16] !== w.seg_start) begin
                $error("seg_start: expected %0d, actual %0d", w.seg_start, data[27:16]);
                errors++;
            end
            if (data[39:28] !== w.seg_end) begin
                $error("seg_end: expected %0d, actual %0d", w.seg_end, data[39:28]);
                errors++;
            end
            if (last !== w.line_done) begin
                $error("line_done: expected %0d, actual %0d", w.line_done, last);
                errors++;
            end
        endfunction
    endclass

    run_scoreboard sb;
    int            pixels_sent = 0;
    bit            s_calm = 1'b0;
    bit            m_calm = 1'b0;

    task automatic send_pixel(input logic [gcrs_pkg::PIX_W-1:0] pix,
                              input logic [gcrs_pkg::POS_W-1:0] pos,
                              input logic last);
        int gap;
        gap = s_calm ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, pos, pix};
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        sb.note_pixel(pix, pos, last);
        pixels_sent++;
        @(negedge aclk);
    endtask

    // pixels that cause no word may still be in flight once the queue is empty
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.seg_q.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic program_ranges(input logic [gcrs_pkg::CFG_W-1:0] white,
                                  input logic [gcrs_pkg::CFG_W-1:0] plate,
                                  input logic [gcrs_pkg::CFG_W-1:0] spring,
                                  input logic [gcrs_pkg::CFG_W-1:0] black,
                                  input logic [gcrs_pkg::CFG_W-1:0] bar,
                                  input bit stray);
        logic [gcrs_pkg::CFG_W-1:0] vals [gcrs_pkg::NUM_RANGES];
        vals = '{white, plate, spring, black, bar};
        for (int i = 0; i < gcrs_pkg::NUM_RANGES; i++) begin
            cfg_we    <= 1'b1;
            cfg_addr  <= REG_IDX[i];
            cfg_wdata <= vals[i];
            sb.set_range(REG_IDX[i], vals[i]);
            @(negedge aclk);
        end
        // index past the last register must be ignored
        if (stray) begin
            cfg_addr  <= gcrs_pkg::CFG_IDX_W'($urandom_range(gcrs_pkg::REG_BAR + 1,
                                                             2**gcrs_pkg::CFG_IDX_W - 1));
            cfg_wdata <= $urandom;
            @(negedge aclk);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic logic [gcrs_pkg::CFG_W-1:0] draw_range();
        int lo;
        int hi;
        case ($urandom_range(0, 11))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_0000;
            2: return 32'hFFFF_FFFF;
            3, 4: begin
                lo = $urandom_range(1, 65535);
                hi = $urandom_range(0, lo - 1);
            end
            default: begin
                lo = $urandom_range(0, 65535);
                hi = lo + $urandom_range(0, 16'h3000);
                if (hi > 65535) hi = 65535;
            end
        endcase
        return {hi[15:0], lo[15:0]};
    endfunction

    // mostly repeat or land inside a programmed band so runs form
    function automatic logic [gcrs_pkg::PIX_W-1:0] pick_pixel(
            logic [gcrs_pkg::PIX_W-1:0] prev);
        int r;
        int lo;
        int hi;
        r = $urandom_range(0, 99);
        if (r < 55) return prev;
        if (r < 85) begin
            r  = $urandom_range(0, gcrs_pkg::NUM_RANGES - 1);
            lo = sb.ranges[REG_IDX[r]][15:0];
            hi = sb.ranges[REG_IDX[r]][31:16];
            if (lo <= hi) return gcrs_pkg::PIX_W'($urandom_range(lo, hi));
        end
        return gcrs_pkg::PIX_W'($urandom);
    endfunction

    task automatic send_line(input int len, input bit ends, input bit scattered);
        logic [gcrs_pkg::POS_W-1:0] pos;
        logic [gcrs_pkg::PIX_W-1:0] pix;
        pos    = gcrs_pkg::POS_W'($urandom);
        pix    = gcrs_pkg::PIX_W'($urandom);
        s_calm = ($urandom_range(0, 4) == 0);
        for (int k = 0; k < len; k++) begin
            pix = pick_pixel(pix);
            send_pixel(pix, pos, ends && (k == len - 1));
            pos = scattered ? gcrs_pkg::POS_W'($urandom) : pos + 1'b1;
        end
    endtask

    initial begin
        m_tready = 1'b0;
        @(negedge aclk);
        while (!aresetn) @(negedge aclk);
        forever begin
            int gap;
            gap = m_calm ? 0 : $urandom_range(0, 4);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_word(m_tdata, m_tlast);
            if ($urandom_range(0, 39) == 0) m_calm = !m_calm;
            @(negedge aclk);
        end
    end

    initial begin
        logic [gcrs_pkg::PIX_W-1:0] long_pix;
        logic [gcrs_pkg::POS_W-1:0] long_pos;
        int target;
        int quota;
        int len;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        sb = new();
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset ranges: only zero is white, everything else other
        send_pixel(16'h0000, 12'd0, 1'b0);
        send_pixel(16'hFFFF, 12'd1, 1'b0);
        send_pixel(16'hFFFF, 12'd2, 1'b1);

        // plate overlaps spring and must win
        settle();
        program_ranges(32'h0FFF_0000, 32'h2FFF_1000, 32'h4FFF_2000, 32'h7FFF_5000,
                       32'hBFFF_8000, 1'b1);
        send_pixel(16'h0FFF, 12'd4094, 1'b0);
        send_pixel(16'h1000, 12'd4095, 1'b0);
        send_pixel(16'h2800, 12'd0, 1'b0);
        send_pixel(16'h3000, 12'd1, 1'b0);
        send_pixel(16'h5000, 12'd2, 1'b0);
        send_pixel(16'hBFFF, 12'd3, 1'b0);
        send_pixel(16'hC000, 12'd4, 1'b0);
        send_pixel(16'h7FFF, 12'd5, 1'b1);   // change and line end together
        send_pixel(16'h4FFF, 12'd4095, 1'b1);
        send_pixel(16'h8000, 12'd4094, 1'b0);
        send_pixel(16'h0000, 12'd0, 1'b0);   // change at position zero wraps the end
        send_pixel(16'hFFFF, 12'hABC, 1'b1);

        // single-value white, full plate, empty bar
        settle();
        program_ranges(32'hFFFF_FFFF, 32'hFFFF_0000, 32'h0000_0000, 32'h0000_0000,
                       32'h0001_FFFF, 1'b0);
        send_pixel(16'hFFFF, 12'd10, 1'b0);
        send_pixel(16'hFFFE, 12'd11, 1'b0);
        send_pixel(16'h0000, 12'd12, 1'b1);

        settle();
        program_ranges(32'h0000_0001, 32'h0000_FFFF, 32'h00FF_0000, 32'h0FFF_0000,
                       32'hFFFF_1000, 1'b1);
        send_pixel(16'h0000, 12'd20, 1'b0);
        send_pixel(16'h0100, 12'd21, 1'b0);
        send_pixel(16'h1000, 12'd22, 1'b1);

        // one run long enough to hit the length cap
        settle();
        program_ranges(draw_range(), draw_range(), draw_range(), draw_range(),
                       draw_range(), 1'b0);
        long_pix = gcrs_pkg::PIX_W'($urandom);
        long_pos = gcrs_pkg::POS_W'($urandom);
        s_calm   = 1'b0;
        for (int k = 0; k < LONG_RUN; k++) begin
            send_pixel(long_pix, long_pos, k == LONG_RUN - 1);
            long_pos = long_pos + 1'b1;
        end

        target = pixels_sent + RANDOM_PIXELS;
        while (pixels_sent < target) begin
            settle();
            program_ranges(draw_range(), draw_range(), draw_range(), draw_range(),
                           draw_range(), $urandom_range(0, 1));
            quota = pixels_sent + $urandom_range(120, 300);
            while (pixels_sent < quota) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3)
                                                  : $urandom_range(2, 60);
                send_line(len, $urandom_range(0, 9) != 0, $urandom_range(0, 7) == 0);
            end
        end

        s_tvalid <= 1'b0;
        while (sb.seg_q.size() != 0) @(negedge aclk);
        repeat (4 * DRAIN_CYCLES) @(negedge aclk);
        if (sb.errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire
